// ===== rtl/two_pkg.sv =====
package two_pkg;

   localparam int CORDIC_STEPS_DEF = 24;

   localparam int CFG_W = 24;

   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_LOAD   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] CSR_WHEEL_DIAM = 2'd0;
   localparam logic [1:0] CSR_LEFT_OFS   = 2'd1;
   localparam logic [1:0] CSR_RIGHT_OFS  = 2'd2;
   localparam logic [1:0] CSR_BACK_OFS   = 2'd3;

   localparam logic [CFG_W-1:0] WHEEL_DIAM_RST = 24'd180224;
   localparam logic [CFG_W-1:0] LEFT_OFS_RST   = 24'd352256;
   localparam logic [CFG_W-1:0] RIGHT_OFS_RST  = 24'd352256;
   localparam logic [CFG_W-1:0] BACK_OFS_RST   = 24'd397312;

   localparam logic signed [32:0] DEG_TO_RAD_HALF = 33'sd37480660;
   localparam logic signed [32:0] FOUR_OVER_PI    = 33'sd1367130551;
   localparam logic signed [33:0] CORDIC_GAIN     = 34'sd652032874;
   localparam logic signed [33:0] QUARTER_TURN    = 34'sd1073741824;
   localparam logic signed [33:0] HALF_TURN       = 34'sd2147483648;
   localparam logic [30:0]        ONE_Q30         = 31'h4000_0000;
   localparam logic [30:0]        MAX_Q31         = 31'h7FFF_FFFF;

   function automatic logic [31:0] two_atan(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h2000_0000;
         5'd1:  v = 32'h12E4_051E;
         5'd2:  v = 32'h09FB_385B;
         5'd3:  v = 32'h0511_11D4;
         5'd4:  v = 32'h028B_0D43;
         5'd5:  v = 32'h0145_D7E1;
         5'd6:  v = 32'h00A2_F61E;
         5'd7:  v = 32'h0051_7C55;
         5'd8:  v = 32'h0028_BE53;
         5'd9:  v = 32'h0014_5F2F;
         5'd10: v = 32'h000A_2F98;
         5'd11: v = 32'h0005_17CC;
         5'd12: v = 32'h0002_8BE6;
         5'd13: v = 32'h0001_45F3;
         5'd14: v = 32'h0000_A2FA;
         5'd15: v = 32'h0000_517D;
         5'd16: v = 32'h0000_28BE;
         5'd17: v = 32'h0000_145F;
         5'd18: v = 32'h0000_0A30;
         5'd19: v = 32'h0000_0518;
         5'd20: v = 32'h0000_028C;
         5'd21: v = 32'h0000_0146;
         5'd22: v = 32'h0000_00A3;
         5'd23: v = 32'h0000_0051;
         5'd24: v = 32'h0000_0029;
         5'd25: v = 32'h0000_0014;
         5'd26: v = 32'h0000_000A;
         5'd27: v = 32'h0000_0005;
         5'd28: v = 32'h0000_0003;
         5'd29: v = 32'h0000_0001;
         5'd30: v = 32'h0000_0001;
         default: v = 32'h0000_0000;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] two_sat32(input logic signed [37:0] v);
      logic signed [31:0] r;
      if (v > 38'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -38'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/two_mul.sv =====
module two_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  a,
   input  logic signed [32:0]  b,
   output logic                done,
   output logic signed [96:0]  p
);

   logic [63:0]        amag_ff, amag_in;
   logic [95:0]        acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               fin_ff, fin_in;
   logic               done_ff, done_in;
   logic signed [96:0] p_ff, p_in;

   logic [63:0] a_abs;
   logic [32:0] b_abs;
   logic [71:0] pp;
   logic [71:0] sum;

   always_comb begin
      a_abs = a[63] ? 64'(-a) : 64'(a);
      b_abs = b[32] ? 33'(-b) : 33'(b);
      pp    = 72'(amag_ff) * 72'(acc_ff[7:0]);
      sum   = {8'b0, acc_ff[95:32]} + pp;

      amag_in = amag_ff;
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      p_in    = p_ff;

      if (start) begin
         amag_in = a_abs;
         acc_in  = {64'b0, b_abs[31:0]};
         neg_in  = a[63] ^ b[32];
         cnt_in  = 2'd0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         acc_in = {sum, acc_ff[31:8]};
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end

      if (fin_ff) begin
         p_in    = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      amag_ff <= amag_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      p_ff    <= p_in;
   end

   assign done = done_ff;
   assign p    = p_ff;

endmodule

// ===== rtl/two_div.sv =====
module two_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [30:0] quo,
   output logic        sat
);

   logic [31:0] rem_ff, rem_in;
   logic [30:0] nlo_ff, nlo_in;
   logic [30:0] q_ff, q_in;
   logic [31:0] den_ff, den_in;
   logic        sat_ff, sat_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;

   logic [32:0] r2;
   logic [32:0] r2_sub;
   logic        qb;

   always_comb begin
      r2     = {rem_ff, nlo_ff[30]};
      r2_sub = r2 - {1'b0, den_ff};
      qb     = (r2 >= {1'b0, den_ff});

      rem_in  = rem_ff;
      nlo_in  = nlo_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;

      if (start) begin
         sat_in = (num >= {1'b0, den, 31'b0});
         rem_in = num[62:31];
         nlo_in = num[30:0];
         den_in = den;
         q_in   = '0;
         cnt_in = 5'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = qb ? r2_sub[31:0] : r2[31:0];
         q_in   = {q_ff[29:0], qb};
         nlo_in = {nlo_ff[29:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd30) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      nlo_ff <= nlo_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      sat_ff <= sat_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;
   assign sat  = sat_ff;

endmodule

// ===== rtl/two_cordic.sv =====
module two_cordic #(
   parameter int CORDIC_STEPS = two_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        ang,
   output logic               done,
   output logic signed [33:0] cos_out,
   output logic signed [33:0] sin_out
);
   import two_pkg::*;

   localparam int CW = $clog2(CORDIC_STEPS);

   logic signed [33:0] x_ff, x_in;
   logic signed [33:0] y_ff, y_in;
   logic signed [33:0] a_ff, a_in;
   logic               neg_ff, neg_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;

   logic signed [33:0] sa;
   logic [4:0]         idx;
   logic signed [33:0] at;
   logic signed [33:0] xs;
   logic signed [33:0] ys;

   always_comb begin
      sa  = $signed({{2{ang[31]}}, ang});
      idx = 5'(cnt_ff);
      at  = $signed({2'b0, two_atan(idx)});
      xs  = x_ff >>> idx;
      ys  = y_ff >>> idx;

      x_in    = x_ff;
      y_in    = y_ff;
      a_in    = a_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;

      if (start) begin
         x_in   = CORDIC_GAIN;
         y_in   = '0;
         cnt_in = '0;
         run_in = 1'b1;
         if (sa > QUARTER_TURN) begin
            a_in   = sa - HALF_TURN;
            neg_in = 1'b1;
         end else if (sa < -QUARTER_TURN) begin
            a_in   = sa + HALF_TURN;
            neg_in = 1'b1;
         end else begin
            a_in   = sa;
            neg_in = 1'b0;
         end
      end else if (run_ff) begin
         if (!a_ff[33]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            a_in = a_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            a_in = a_ff + at;
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(CORDIC_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      a_ff   <= a_in;
      neg_ff <= neg_in;
   end

   assign done    = done_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;

endmodule

// ===== rtl/tracking_wheel_odometry.sv =====
// Three-wheel arc odometry engine.
// req_ carries one item: an opcode and flag in tuser, encoder angles,
// fused heading and load position in tdata. rsp_ returns exactly one item
// per request: position x, y and heading after the step.
// csr_ writes wheel diameter and wheel offsets; the user must do so only
// at idle time, since the block does not enforce it. An update item runs
// at most fifteen products on the shared multiplier, two quotients on the
// shared divider and two CORDIC passes; a zero track sum or zero heading
// change skips the heading, sine and arc correction steps. Load, clear and
// unused opcodes go straight to the output state.
// One item is in work at a time; req_tready is high only while idle.
// The result waits in an output register when rsp_tready is low, and the
// next request is accepted meanwhile; its own result holds until the
// register frees.
// reset clears position, heading and saved angles and restores the
// register defaults.
module tracking_wheel_odometry #(
   parameter int CORDIC_STEPS = two_pkg::CORDIC_STEPS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // left_count, right_count, back_count, fused_heading, load_x, load_y
   input  logic [175:0]              req_tdata,
   // opcode, heading_valid
   input  logic [2:0]                req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // pos_x, pos_y, heading_out
   output logic [79:0]               rsp_tdata,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [two_pkg::CFG_W-1:0] csr_wdata
);
   import two_pkg::*;

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_OUT    = 5'd1;
   localparam logic [4:0] ST_TRV_A  = 5'd2;
   localparam logic [4:0] ST_TRV_AW = 5'd3;
   localparam logic [4:0] ST_TRV_B  = 5'd4;
   localparam logic [4:0] ST_TRV_BW = 5'd5;
   localparam logic [4:0] ST_DIV_D  = 5'd6;
   localparam logic [4:0] ST_DIV_DW = 5'd7;
   localparam logic [4:0] ST_H      = 5'd8;
   localparam logic [4:0] ST_HW     = 5'd9;
   localparam logic [4:0] ST_SIN    = 5'd10;
   localparam logic [4:0] ST_SINW   = 5'd11;
   localparam logic [4:0] ST_C      = 5'd12;
   localparam logic [4:0] ST_CW     = 5'd13;
   localparam logic [4:0] ST_LX1    = 5'd14;
   localparam logic [4:0] ST_LX1W   = 5'd15;
   localparam logic [4:0] ST_LX2    = 5'd16;
   localparam logic [4:0] ST_LX2W   = 5'd17;
   localparam logic [4:0] ST_LY1    = 5'd18;
   localparam logic [4:0] ST_LY1W   = 5'd19;
   localparam logic [4:0] ST_LY2    = 5'd20;
   localparam logic [4:0] ST_LY2W   = 5'd21;
   localparam logic [4:0] ST_ROT    = 5'd22;
   localparam logic [4:0] ST_ROTW   = 5'd23;
   localparam logic [4:0] ST_NX1    = 5'd24;
   localparam logic [4:0] ST_NX1W   = 5'd25;
   localparam logic [4:0] ST_NX2    = 5'd26;
   localparam logic [4:0] ST_NX2W   = 5'd27;
   localparam logic [4:0] ST_NY1    = 5'd28;
   localparam logic [4:0] ST_NY1W   = 5'd29;
   localparam logic [4:0] ST_NY2    = 5'd30;
   localparam logic [4:0] ST_NY2W   = 5'd31;

   logic [4:0]         state_ff, state_in;
   logic [CFG_W-1:0]   wd_ff, wd_in, lo_ff, lo_in, ro_ff, ro_in, bo_ff, bo_in;
   logic signed [31:0] prev_ff [0:2];
   logic signed [31:0] prev_in [0:2];
   logic signed [32:0] dd_ff [0:2];
   logic signed [32:0] dd_in [0:2];
   logic signed [31:0] dist_ff [0:2];
   logic signed [31:0] dist_in [0:2];
   logic [1:0]         k_ff, k_in;
   logic signed [31:0] posx_ff, posx_in, posy_ff, posy_in;
   logic [15:0]        head_ff, head_in;
   logic [55:0]        prod_ff, prod_in;
   logic signed [31:0] d_ff, d_in, c_ff, c_in;
   logic signed [33:0] h_ff, h_in, s_ff, s_in, tmp_ff, tmp_in;
   logic signed [33:0] lx_ff, lx_in, ly_ff, ly_in;
   logic signed [32:0] cs_ff, cs_in, sn_ff, sn_in;
   logic signed [65:0] m_ff, m_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [79:0]        rsp_data_ff, rsp_data_in;

   logic               mul_start, mul_done;
   logic signed [63:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [96:0] mul_p;
   logic               div_start, div_done, div_sat;
   logic [63:0]        div_num;
   logic [31:0]        div_den;
   logic [30:0]        div_q;
   logic               cor_start, cor_done;
   logic [31:0]        cor_ang;
   logic signed [33:0] cor_cos, cor_sin;

   two_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   two_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_q),
      .sat   (div_sat)
   );

   two_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .ang     (cor_ang),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   logic [1:0]         req_op;
   logic signed [31:0] req_cnt [0:2];
   logic signed [32:0] dd_sel;
   logic [32:0]        dd_mag;
   logic [30:0]        trv_r;
   logic signed [31:0] trv_dist;
   logic [24:0]        t_sum;
   logic signed [32:0] diff_lr;
   logic [32:0]        lr_mag;
   logic [30:0]        q_d;
   logic signed [31:0] d_val;
   logic [33:0]        s_mag;
   logic [31:0]        d_mag;
   logic [30:0]        c_mag;
   logic signed [66:0] rot_sum;
   logic signed [36:0] rot_n;
   logic signed [33:0] b_ext, r_ext;
   logic signed [37:0] pos_sum_x, pos_sum_y;

   always_comb begin
      req_op     = req_tuser[1:0];
      req_cnt[0] = req_tdata[31:0];
      req_cnt[1] = req_tdata[63:32];
      req_cnt[2] = req_tdata[95:64];

      dd_sel   = dd_ff[k_ff];
      dd_mag   = dd_sel[32] ? 33'(-dd_sel) : 33'(dd_sel);
      trv_r    = (mul_p[95:63] != '0) ? MAX_Q31 : mul_p[62:32];
      trv_dist = dd_sel[32] ? -$signed({1'b0, trv_r}) : $signed({1'b0, trv_r});

      t_sum   = {1'b0, lo_ff} + {1'b0, ro_ff};
      diff_lr = $signed({dist_ff[0][31], dist_ff[0]}) - $signed({dist_ff[1][31], dist_ff[1]});
      lr_mag  = diff_lr[32] ? 33'(-diff_lr) : 33'(diff_lr);
      q_d     = div_sat ? MAX_Q31 : div_q;
      d_val   = diff_lr[32] ? -$signed({1'b0, q_d}) : $signed({1'b0, q_d});

      s_mag = s_ff[33] ? 34'(-s_ff) : 34'(s_ff);
      d_mag = d_ff[31] ? 32'(-d_ff) : 32'(d_ff);
      c_mag = (div_sat || (div_q > ONE_Q30)) ? ONE_Q30 : div_q;

      b_ext = $signed({{2{dist_ff[2][31]}}, dist_ff[2]});
      r_ext = $signed({{2{dist_ff[1][31]}}, dist_ff[1]});

      if (state_ff == ST_NX2W) begin
         rot_sum = $signed({m_ff[65], m_ff}) - $signed({mul_p[65], mul_p[65:0]});
      end else begin
         rot_sum = $signed({m_ff[65], m_ff}) + $signed({mul_p[65], mul_p[65:0]});
      end
      rot_n     = rot_sum[66:30];
      pos_sum_x = $signed({{6{posx_ff[31]}}, posx_ff}) + $signed({rot_n[36], rot_n});
      pos_sum_y = $signed({{6{posy_ff[31]}}, posy_ff}) + $signed({rot_n[36], rot_n});
   end

   always_comb begin
      state_in = state_ff;
      wd_in    = wd_ff;
      lo_in    = lo_ff;
      ro_in    = ro_ff;
      bo_in    = bo_ff;
      for (int i = 0; i < 3; i++) begin
         prev_in[i] = prev_ff[i];
         dd_in[i]   = dd_ff[i];
         dist_in[i] = dist_ff[i];
      end
      k_in         = k_ff;
      posx_in      = posx_ff;
      posy_in      = posy_ff;
      head_in      = head_ff;
      prod_in      = prod_ff;
      d_in         = d_ff;
      c_in         = c_ff;
      h_in         = h_ff;
      s_in         = s_ff;
      tmp_in       = tmp_ff;
      lx_in        = lx_ff;
      ly_in        = ly_ff;
      cs_in        = cs_ff;
      sn_in        = sn_ff;
      m_in         = m_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      cor_start = 1'b0;
      cor_ang   = '0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_WHEEL_DIAM: wd_in = csr_wdata;
            CSR_LEFT_OFS:   lo_in = csr_wdata;
            CSR_RIGHT_OFS:  ro_in = csr_wdata;
            CSR_BACK_OFS:   bo_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_op)
                  OP_UPDATE: begin
                     for (int i = 0; i < 3; i++) begin
                        dd_in[i]   = $signed({req_cnt[i][31], req_cnt[i]})
                                   - $signed({prev_ff[i][31], prev_ff[i]});
                        prev_in[i] = req_cnt[i];
                     end
                     if (req_tuser[2]) begin
                        head_in = req_tdata[111:96];
                     end
                     k_in     = 2'd0;
                     state_in = ST_TRV_A;
                  end
                  OP_LOAD: begin
                     posx_in  = req_tdata[143:112];
                     posy_in  = req_tdata[175:144];
                     state_in = ST_OUT;
                  end
                  OP_CLEAR: begin
                     for (int i = 0; i < 3; i++) begin
                        prev_in[i] = '0;
                     end
                     posx_in  = '0;
                     posy_in  = '0;
                     head_in  = '0;
                     state_in = ST_OUT;
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {head_ff, posy_ff, posx_ff};
               state_in     = ST_IDLE;
            end
         end
         ST_TRV_A: begin
            mul_start = 1'b1;
            mul_a     = $signed({32'b0, dd_mag[31:0]});
            mul_b     = $signed({9'b0, wd_ff});
            state_in  = ST_TRV_AW;
         end
         ST_TRV_AW: begin
            if (mul_done) begin
               prod_in  = mul_p[55:0];
               state_in = ST_TRV_B;
            end
         end
         ST_TRV_B: begin
            mul_start = 1'b1;
            mul_a     = $signed({8'b0, prod_ff});
            mul_b     = DEG_TO_RAD_HALF;
            state_in  = ST_TRV_BW;
         end
         ST_TRV_BW: begin
            if (mul_done) begin
               dist_in[k_ff] = trv_dist;
               k_in          = k_ff + 2'd1;
               state_in      = (k_ff == 2'd2) ? ST_DIV_D : ST_TRV_A;
            end
         end
         ST_DIV_D: begin
            if (t_sum == '0) begin
               d_in     = '0;
               h_in     = '0;
               lx_in    = b_ext;
               ly_in    = r_ext;
               state_in = ST_ROT;
            end else begin
               div_start = 1'b1;
               div_num   = {4'b0, lr_mag[31:0], 28'b0};
               div_den   = {7'b0, t_sum};
               state_in  = ST_DIV_DW;
            end
         end
         ST_DIV_DW: begin
            if (div_done) begin
               d_in = d_val;
               if (d_val == '0) begin
                  h_in     = '0;
                  lx_in    = b_ext;
                  ly_in    = r_ext;
                  state_in = ST_ROT;
               end else begin
                  state_in = ST_H;
               end
            end
         end
         ST_H: begin
            mul_start = 1'b1;
            mul_a     = $signed({{32{d_ff[31]}}, d_ff});
            mul_b     = FOUR_OVER_PI;
            state_in  = ST_HW;
         end
         ST_HW: begin
            if (mul_done) begin
               h_in     = mul_p[63:30];
               state_in = ST_SIN;
            end
         end
         ST_SIN: begin
            cor_start = 1'b1;
            cor_ang   = h_ff[31:0];
            state_in  = ST_SINW;
         end
         ST_SINW: begin
            if (cor_done) begin
               s_in     = cor_sin;
               state_in = ST_C;
            end
         end
         ST_C: begin
            div_start = 1'b1;
            div_num   = {3'b0, s_mag[31:0], 29'b0};
            div_den   = d_mag;
            state_in  = ST_CW;
         end
         ST_CW: begin
            if (div_done) begin
               c_in     = (s_ff[33] ^ d_ff[31]) ? -$signed({1'b0, c_mag})
                                                : $signed({1'b0, c_mag});
               state_in = ST_LX1;
            end
         end
         ST_LX1: begin
            mul_start = 1'b1;
            mul_a     = $signed({{32{dist_ff[2][31]}}, dist_ff[2]});
            mul_b     = $signed({c_ff[31], c_ff});
            state_in  = ST_LX1W;
         end
         ST_LX1W: begin
            if (mul_done) begin
               tmp_in   = mul_p[63:30];
               state_in = ST_LX2;
            end
         end
         ST_LX2: begin
            mul_start = 1'b1;
            mul_a     = $signed({{30{s_ff[33]}}, s_ff});
            mul_b     = $signed({9'b0, bo_ff});
            state_in  = ST_LX2W;
         end
         ST_LX2W: begin
            if (mul_done) begin
               lx_in    = tmp_ff + mul_p[62:29];
               state_in = ST_LY1;
            end
         end
         ST_LY1: begin
            mul_start = 1'b1;
            mul_a     = $signed({{32{dist_ff[1][31]}}, dist_ff[1]});
            mul_b     = $signed({c_ff[31], c_ff});
            state_in  = ST_LY1W;
         end
         ST_LY1W: begin
            if (mul_done) begin
               tmp_in   = mul_p[63:30];
               state_in = ST_LY2;
            end
         end
         ST_LY2: begin
            mul_start = 1'b1;
            mul_a     = $signed({{30{s_ff[33]}}, s_ff});
            mul_b     = $signed({9'b0, ro_ff});
            state_in  = ST_LY2W;
         end
         ST_LY2W: begin
            if (mul_done) begin
               ly_in    = tmp_ff + mul_p[62:29];
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            cor_start = 1'b1;
            cor_ang   = h_ff[31:0] - {head_ff, 16'b0};
            state_in  = ST_ROTW;
         end
         ST_ROTW: begin
            if (cor_done) begin
               cs_in    = cor_cos[32:0];
               sn_in    = cor_sin[32:0];
               state_in = ST_NX1;
            end
         end
         ST_NX1: begin
            mul_start = 1'b1;
            mul_a     = $signed({{30{lx_ff[33]}}, lx_ff});
            mul_b     = cs_ff;
            state_in  = ST_NX1W;
         end
         ST_NX1W: begin
            if (mul_done) begin
               m_in     = mul_p[65:0];
               state_in = ST_NX2;
            end
         end
         ST_NX2: begin
            mul_start = 1'b1;
            mul_a     = $signed({{30{ly_ff[33]}}, ly_ff});
            mul_b     = sn_ff;
            state_in  = ST_NX2W;
         end
         ST_NX2W: begin
            if (mul_done) begin
               posx_in  = two_sat32(pos_sum_x);
               state_in = ST_NY1;
            end
         end
         ST_NY1: begin
            mul_start = 1'b1;
            mul_a     = $signed({{30{ly_ff[33]}}, ly_ff});
            mul_b     = cs_ff;
            state_in  = ST_NY1W;
         end
         ST_NY1W: begin
            if (mul_done) begin
               m_in     = mul_p[65:0];
               state_in = ST_NY2;
            end
         end
         ST_NY2: begin
            mul_start = 1'b1;
            mul_a     = $signed({{30{lx_ff[33]}}, lx_ff});
            mul_b     = sn_ff;
            state_in  = ST_NY2W;
         end
         ST_NY2W: begin
            if (mul_done) begin
               posy_in  = two_sat32(pos_sum_y);
               state_in = ST_OUT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wd_ff        <= WHEEL_DIAM_RST;
         lo_ff        <= LEFT_OFS_RST;
         ro_ff        <= RIGHT_OFS_RST;
         bo_ff        <= BACK_OFS_RST;
         for (int i = 0; i < 3; i++) begin
            prev_ff[i] <= '0;
         end
         k_ff         <= 2'd0;
         posx_ff      <= '0;
         posy_ff      <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wd_ff        <= wd_in;
         lo_ff        <= lo_in;
         ro_ff        <= ro_in;
         bo_ff        <= bo_in;
         for (int i = 0; i < 3; i++) begin
            prev_ff[i] <= prev_in[i];
         end
         k_ff         <= k_in;
         posx_ff      <= posx_in;
         posy_ff      <= posy_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dd_ff[i]   <= dd_in[i];
         dist_ff[i] <= dist_in[i];
      end
      prod_ff     <= prod_in;
      d_ff        <= d_in;
      c_ff        <= c_in;
      h_ff        <= h_in;
      s_ff        <= s_in;
      tmp_ff      <= tmp_in;
      lx_ff       <= lx_in;
      ly_ff       <= ly_in;
      cs_ff       <= cs_in;
      sn_ff       <= sn_in;
      m_ff        <= m_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== verif/odometry_checker.sv =====
module odometry_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [175:0]              req_tdata,
   input  logic [2:0]                req_tuser,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [79:0]               rsp_tdata,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [two_pkg::CFG_W-1:0] csr_wdata,
   output int                        fail_count,
   output int                        pending,
   output int                        checked_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import two_pkg::*;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [15:0]        heading;
   } pose_type;

   localparam longint DEG_HALF_K  = 64'd37480660;
   localparam longint FOUR_PI_K   = 64'd1367130551;
   localparam longint GAIN_K      = 64'd652032874;
   localparam longint ONE_HALF_T  = 64'd2147483648;
   localparam longint ONE_QUART_T = 64'd1073741824;
   localparam longint UNIT_Q30    = 64'd1073741824;
   localparam longint I32_MAX     = 64'd2147483647;
   localparam longint I32_MIN     = -64'd2147483648;

   localparam logic [31:0] ARC_STEP [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000};

   logic [23:0] diam_q, left_ofs_q, right_ofs_q, back_ofs_q;
   longint      last_left, last_right, last_back, cur_x, cur_y;
   logic [15:0] cur_heading;
   pose_type    pose_queue[$];

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint wheel_travel(longint dd);
      longint unsigned mag, prod, hi, lo, t, r;
      mag  = dd < 0 ? -dd : dd;
      prod = mag * longint'(diam_q);
      hi   = prod >> 24;
      lo   = prod & 64'hFFFFFF;
      t    = hi * DEG_HALF_K;
      r    = (t >> 8) + ((((t & 64'hFF) << 24) + lo * DEG_HALF_K) >> 32);
      if (r > I32_MAX) r = I32_MAX;
      return dd < 0 ? -longint'(r) : longint'(r);
   endfunction

   function automatic void sin_cos(input logic [31:0] ang, output longint co,
                                   output longint si);
      longint a, x, y, nx;
      bit     flip;
      a = ang;
      x = GAIN_K;
      y = 0;
      flip = 0;
      if (a >= ONE_HALF_T) a -= 2 * ONE_HALF_T;
      if (a > ONE_QUART_T) begin
         a -= ONE_HALF_T;
         flip = 1;
      end else if (a < -ONE_QUART_T) begin
         a += ONE_HALF_T;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
         if (a >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            a -= longint'(ARC_STEP[i]);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            a += longint'(ARC_STEP[i]);
         end
         x = nx;
      end
      co = flip ? -x : x;
      si = flip ? -y : y;
   endfunction

   function automatic void advance_pose(logic [175:0] d, logic hv);
      longint cl, cr, cb, tl, tr, tb, track, dth, half, lx, ly, cs, sn, s, cu, c;
      logic [31:0] phi;
      cl = $signed(d[31:0]);
      cr = $signed(d[63:32]);
      cb = $signed(d[95:64]);
      tl = wheel_travel(cl - last_left);
      tr = wheel_travel(cr - last_right);
      tb = wheel_travel(cb - last_back);
      track = longint'(left_ofs_q) + longint'(right_ofs_q);
      last_left = cl;
      last_right = cr;
      last_back = cb;
      if (hv) cur_heading = d[111:96];
      dth = 0;
      half = 0;
      if (track != 0) dth = clip(((tl - tr) * (64'sd1 << 28)) / track, -I32_MAX, I32_MAX);
      if (dth != 0) begin
         half = (dth * FOUR_PI_K) >>> 30;
         sin_cos(half[31:0], cu, s);
         c  = clip((s * (64'sd1 << 29)) / dth, -UNIT_Q30, UNIT_Q30);
         lx = ((tb * c) >>> 30) + ((2 * s * longint'(back_ofs_q)) >>> 30);
         ly = ((tr * c) >>> 30) + ((2 * s * longint'(right_ofs_q)) >>> 30);
      end else begin
         lx = tb;
         ly = tr;
      end
      phi = half[31:0] - {cur_heading, 16'h0};
      sin_cos(phi, cs, sn);
      cur_x = clip(cur_x + ((lx * cs - ly * sn) >>> 30), I32_MIN, I32_MAX);
      cur_y = clip(cur_y + ((ly * cs + lx * sn) >>> 30), I32_MIN, I32_MAX);
   endfunction

   function automatic void clear_pose();
      last_left = 0;
      last_right = 0;
      last_back = 0;
      cur_x = 0;
      cur_y = 0;
      cur_heading = 0;
   endfunction

   always @(posedge clock) begin
      pose_type got, want;
      if (reset) begin
         diam_q <= WHEEL_DIAM_RST;
         left_ofs_q <= LEFT_OFS_RST;
         right_ofs_q <= RIGHT_OFS_RST;
         back_ofs_q <= BACK_OFS_RST;
         clear_pose();
         pose_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WHEEL_DIAM: diam_q <= csr_wdata;
               CSR_LEFT_OFS:   left_ofs_q <= csr_wdata;
               CSR_RIGHT_OFS:  right_ofs_q <= csr_wdata;
               CSR_BACK_OFS:   back_ofs_q <= csr_wdata;
            endcase
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser[1:0])
               OP_UPDATE: advance_pose(req_tdata, req_tuser[2]);
               OP_LOAD: begin
                  cur_x = $signed(req_tdata[143:112]);
                  cur_y = $signed(req_tdata[175:144]);
               end
               OP_CLEAR: clear_pose();
               default: ;
            endcase
            want.pos_x = cur_x[31:0];
            want.pos_y = cur_y[31:0];
            want.heading = cur_heading;
            pose_queue.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.pos_x = rsp_tdata[31:0];
            got.pos_y = rsp_tdata[63:32];
            got.heading = rsp_tdata[79:64];
            if (pose_queue.size() == 0) begin
               $error("unexpected item: pos_x %0d pos_y %0d heading %0d",
                      got.pos_x, got.pos_y, got.heading);
               fail_count++;
            end else begin
               want = pose_queue.pop_front();
               checked_count++;
               if (got.pos_x !== want.pos_x) begin
                  $error("pos_x expected %0d actual %0d", want.pos_x, got.pos_x);
                  fail_count++;
               end
               if (got.pos_y !== want.pos_y) begin
                  $error("pos_y expected %0d actual %0d", want.pos_y, got.pos_y);
                  fail_count++;
               end
               if (got.heading !== want.heading) begin
                  $error("heading_out expected %0d actual %0d", want.heading, got.heading);
                  fail_count++;
               end
            end
         end
      end
      pending = pose_queue.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      checked_count = 0;
   end
endmodule

// ===== verif/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import two_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_tvalid = 0;
   logic                 req_tready;
   // left_count, right_count, back_count, fused_heading, load_x, load_y
   logic [175:0]         req_tdata = '0;
   // opcode, heading_valid
   logic [2:0]           req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 0;
   // pos_x, pos_y, heading_out
   logic [79:0]          rsp_tdata;
   logic                 csr_we = 0;
   logic [1:0]           csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;
   int                   fail_count, pending, checked_count;
   int                   send_idle_pct = 0, recv_idle_pct = 0;
   int                   hold_left = 0, cycles = 0, items_sent = 0;
   bit                   hold_go = 0, hold_done = 0;
   logic signed [31:0]   enc_l = 0, enc_r = 0, enc_b = 0;

   tracking_wheel_odometry dut (.*);

   odometry_checker checker_i (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done <= 1;
         hold_left <= 3000;
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   task automatic send_item(input logic [1:0] op, input logic hv, input logic [31:0] l,
                            input logic [31:0] r, input logic [31:0] b,
                            input logic [15:0] fh, input logic [31:0] lx,
                            input logic [31:0] ly);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= {hv, op};
      req_tdata <= {ly, lx, fh, b, r, l};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (op == OP_CLEAR) begin
         enc_l = 0;
         enc_r = 0;
         enc_b = 0;
      end else if (op == OP_UPDATE) begin
         enc_l = l;
         enc_r = r;
         enc_b = b;
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [CFG_W-1:0] v);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic set_geometry(input logic [CFG_W-1:0] wd, input logic [CFG_W-1:0] lo,
                               input logic [CFG_W-1:0] ro, input logic [CFG_W-1:0] bo);
      write_csr(CSR_WHEEL_DIAM, wd);
      write_csr(CSR_LEFT_OFS, lo);
      write_csr(CSR_RIGHT_OFS, ro);
      write_csr(CSR_BACK_OFS, bo);
   endtask

   task automatic random_item();
      int pick;
      logic [31:0] l, r, b;
      pick = $urandom_range(99);
      if (pick < 4) begin
         send_item(OP_LOAD, 1'($urandom), $urandom, $urandom, $urandom, 16'($urandom),
                   $urandom, $urandom);
      end else if (pick < 7) begin
         send_item(OP_CLEAR, 1'($urandom), $urandom, $urandom, $urandom, 16'($urandom),
                   $urandom, $urandom);
      end else if (pick < 9) begin
         send_item(2'd3, 1'($urandom), $urandom, $urandom, $urandom, 16'($urandom),
                   $urandom, $urandom);
      end else if (pick < 19) begin
         send_item(OP_UPDATE, 1'($urandom), $urandom, $urandom, $urandom, 16'($urandom),
                   $urandom, $urandom);
      end else begin
         l = enc_l + $signed($urandom_range(2000)) - 1000;
         r = ($urandom_range(3) == 0) ? l : enc_r + $signed($urandom_range(2000)) - 1000;
         b = enc_b + $signed($urandom_range(600)) - 300;
         send_item(OP_UPDATE, $urandom_range(3) != 0, l, r, b, 16'($urandom), $urandom,
                   $urandom);
      end
   endtask

   initial begin
      logic [CFG_W-1:0] geo [6][4];
      geo = '{'{WHEEL_DIAM_RST, LEFT_OFS_RST, RIGHT_OFS_RST, BACK_OFS_RST},
              '{24'd1, 24'd0, 24'd0, 24'd0},
              '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
              '{24'd131072, 24'd1, 24'd0, 24'd65536},
              '{24'd500000, 24'd100000, 24'd400000, 24'hFFFFFF},
              '{24'd180224, 24'd352256, 24'd352256, 24'd397312}};
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners under reset geometry
      send_item(OP_UPDATE, 0, 0, 0, 0, 16'h0, 0, 0);
      send_item(OP_UPDATE, 1, 360, 360, 0, 16'h0, 0, 0);
      send_item(OP_UPDATE, 1, 720, 0, 90, 16'h4000, 0, 0);
      send_item(OP_UPDATE, 0, 700, 900, -90, 16'hFFFF, 0, 0);
      send_item(OP_UPDATE, 1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h8000, 0, 0);
      send_item(OP_UPDATE, 1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 0, 0);
      send_item(OP_LOAD, 1, 0, 0, 0, 0, 32'h7FFFFFF0, 32'h80000010);
      send_item(OP_UPDATE, 1, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 16'h0, 0, 0);
      send_item(OP_LOAD, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
                32'h80000000, 32'h7FFFFFFF);
      send_item(OP_UPDATE, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 16'h0, 0, 0);
      send_item(2'd3, 1, 32'hFFFFFFFF, 0, 0, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_item(OP_UPDATE, 1, 32'h7FFFFF00, 32'h7FFFFF00, 32'h7FFFFF10, 16'h2000, 0, 0);
      send_item(OP_CLEAR, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
                32'hFFFFFFFF, 32'hFFFFFFFF);
      send_item(OP_UPDATE, 1, -5, 5, 1, 16'hC000, 0, 0);
      send_item(OP_UPDATE, 0, 1000000, -1000000, 0, 16'h1234, 0, 0);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         set_geometry(geo[ph][0], geo[ph][1], geo[ph][2], geo[ph][3]);
         send_idle_pct = (ph % 3 == 0) ? 17 : (ph % 3 == 1) ? 57 : 0;
         recv_idle_pct = (ph % 3 == 0) ? 57 : (ph % 3 == 1) ? 17 : 0;
         for (int n = 0; n < 245; n++) begin
            if (ph == 0 && n == 40) hold_go = 1;
            random_item();
         end
      end

      drain();
      $display("Ran %0d items over 6 geometry settings incl. zero track and max sizes;",
               items_sent);
      $display("checked %0d results with sender/receiver stalls and a long back-pressure hold.",
               checked_count);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
